FILE: rtl/core/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int DATA_W = 32;
    localparam int KEY_IN_W = 32;
    localparam int CFG_W = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic                       cmd;
        logic signed [KEY_IN_W-1:0] lookup_key;
        logic signed [DATA_W-1:0]   write_value;
    } t_in_word;

    typedef struct packed {
        logic                       hit;
        logic signed [DATA_W-1:0]   read_value;
        logic                       evicted;
        logic signed [KEY_IN_W-1:0] evicted_key;
    } t_out_word;

    // per-entry update command from the lookup logic
    typedef struct packed {
        logic update;    // ranks change this cycle
        logic age_all;   // every valid entry ages (new entry filled)
        logic target;    // this entry becomes most recent
        logic load_key;  // this entry takes the new key
    } t_entry_cmd;

    typedef struct packed {
        logic valid;
        logic match;
        logic lru;
    } t_entry_stat;

endpackage

FILE: rtl/core/lkvc_ram.sv
`timescale 1ns / 1ps

module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lkvc_entry.sv
`timescale 1ns / 1ps

module lkvc_entry
    import lkvc_pkg::*;
#(
    parameter int KEY_BITS = 32,
    parameter int RANK_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_entry_cmd          i_cmd,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [RANK_W-1:0]   i_old_rank,
    input  logic [RANK_W-1:0]   i_lru_rank,
    output t_entry_stat         o_stat,
    output logic [RANK_W-1:0]   o_rank,
    output logic [KEY_BITS-1:0] o_key
);

    logic                r_valid;
    logic [RANK_W-1:0]   r_rank;
    logic [KEY_BITS-1:0] r_key;
    logic                n_valid;
    logic [RANK_W-1:0]   n_rank;

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_cmd.update) begin
            if (i_cmd.target) begin
                n_rank = '0;
                if (i_cmd.load_key) begin
                    n_valid = 1'b1;
                end
            end else if (r_valid && (i_cmd.age_all || (r_rank < i_old_rank))) begin
                n_rank = r_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && i_cmd.target && i_cmd.load_key) begin
            r_key <= i_key;
        end
    end

    assign o_stat.valid = r_valid;
    assign o_stat.match = r_valid && (r_key == i_key);
    assign o_stat.lru   = r_valid && (r_rank == i_lru_rank);
    assign o_rank       = r_rank;
    assign o_key        = r_key;

endmodule

FILE: rtl/core/lru_key_value_cache_unit.sv
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// One word is accepted every clock cycle unless the output stalls; each word
// passes the input register, then the result register, and the logic between
// the two holds the parallel compare of the key against every entry plus the
// rank update of all entries, which sets the clock limit.
// Values live in a RAM whose registered read doubles as the result register.
// Ranks run from 0 (most recent); when the cache is full the entry with rank
// fill count minus one is replaced. A capacity write is ignored unless the
// cache is empty; zero is taken as one and values above MAX_ENTRIES as
// MAX_ENTRIES. Keys keep only their low KEY_BITS bits after sign extension.
module lru_key_value_cache_unit
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_data
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_RESET = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;

    logic            r_in_valid;
    t_in_word        r_in;
    logic            r_out_valid;
    logic            r_out_hit;
    logic            r_out_cmd;
    logic            r_out_evicted;
    logic [KEY_IN_W-1:0] r_out_evk;
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   r_capacity;
    logic [CW-1:0]   n_capacity;

    logic                   adv;
    logic [63:0]            key_ext;
    logic [KEY_BITS-1:0]    key_w;
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] lru_vec;
    logic [MAX_ENTRIES-1:0] valid_vec;
    logic [MAX_ENTRIES-1:0] fill_oh;
    logic [MAX_ENTRIES-1:0] target_oh;
    logic [IW-1:0]          rank_arr [MAX_ENTRIES];
    logic [KEY_BITS-1:0]    key_arr [MAX_ENTRIES];
    t_entry_stat            stat_arr [MAX_ENTRIES];
    t_entry_cmd             cmd_arr [MAX_ENTRIES];
    logic [IW-1:0]          target_idx;
    logic [IW-1:0]          old_rank;
    logic [KEY_BITS-1:0]    lru_key;
    logic [63:0]            lru_key_ext;
    logic [CW-1:0]          fill_m1;
    logic [IW-1:0]          lru_rank;
    logic                   is_get;
    logic                   hit;
    logic                   full;
    logic                   evict;
    logic                   fill_op;
    logic                   ranks_change;
    logic [DATA_W-1:0]      ram_rdata;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // sign-extend, then keep KEY_BITS
    assign key_ext = {{(64 - KEY_IN_W){r_in.lookup_key[KEY_IN_W-1]}}, r_in.lookup_key};
    assign key_w   = key_ext[KEY_BITS-1:0];

    assign fill_m1  = r_fill - CW'(1);
    assign lru_rank = fill_m1[IW-1:0];

    assign is_get       = (r_in.cmd == CMD_GET);
    assign hit          = |match_vec;
    assign full         = (r_fill >= r_capacity);
    assign evict        = !is_get && !hit && full;
    assign fill_op      = !is_get && !hit && !full;
    assign ranks_change = adv && (hit || !is_get);

    always_comb begin
        target_idx = '0;
        old_rank   = '0;
        lru_key    = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            fill_oh[i] = (r_fill == CW'(i));
        end
        if (hit) begin
            target_oh = match_vec;
        end else if (evict) begin
            target_oh = lru_vec;
        end else if (fill_op) begin
            target_oh = fill_oh;
        end else begin
            target_oh = '0;
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (target_oh[i]) begin
                target_idx = target_idx | IW'(i);
            end
            old_rank = old_rank | (rank_arr[i] & {IW{target_oh[i]}});
            lru_key  = lru_key | (key_arr[i] & {KEY_BITS{lru_vec[i]}});
        end
    end

    assign lru_key_ext = 64'(lru_key);

    generate
        for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_entry
            assign cmd_arr[g].update   = ranks_change;
            assign cmd_arr[g].age_all  = fill_op;
            assign cmd_arr[g].target   = target_oh[g];
            assign cmd_arr[g].load_key = evict || fill_op;

            lkvc_entry #(
                .KEY_BITS (KEY_BITS),
                .RANK_W   (IW)
            ) u_entry (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (cmd_arr[g]),
                .i_key      (key_w),
                .i_old_rank (old_rank),
                .i_lru_rank (lru_rank),
                .o_stat     (stat_arr[g]),
                .o_rank     (rank_arr[g]),
                .o_key      (key_arr[g])
            );

            assign match_vec[g] = stat_arr[g].match;
            assign lru_vec[g]   = stat_arr[g].lru;
            assign valid_vec[g] = stat_arr[g].valid;
        end
    endgenerate

    lkvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (adv && !is_get),
        .i_waddr (target_idx),
        .i_wdata (r_in.write_value),
        .i_re    (adv && is_get && hit),
        .i_raddr (target_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_capacity = CW'(1);
        end else if (32'(i_cfg_wdata) > MAX_ENTRIES) begin
            n_capacity = CW'(MAX_ENTRIES);
        end else begin
            n_capacity = CW'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_capacity  <= CW'(CAP_RESET);
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv && fill_op) begin
                r_fill <= r_fill + CW'(1);
            end
            if (i_cfg_we && (r_fill == '0)) begin
                r_capacity <= n_capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out_hit     <= hit;
            r_out_cmd     <= r_in.cmd;
            r_out_evicted <= evict;
            r_out_evk     <= evict ? lru_key_ext[KEY_IN_W-1:0] : '0;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_out_data.hit         = r_out_hit;
    assign o_out_data.read_value  = (r_out_cmd == CMD_GET)
                                    ? (r_out_hit ? ram_rdata : MISS_VALUE) : '0;
    assign o_out_data.evicted     = r_out_evicted;
    assign o_out_data.evicted_key = r_out_evk;

    a_fill_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_capacity)
        else $error("fill count above capacity");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match_vec))
        else $error("key present in more than one entry");

    a_lru_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && full) |-> $onehot(lru_vec))
        else $error("no single least recent entry in a full cache");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == 32'(r_fill))
        else $error("valid entries disagree with fill count");

    a_evict_on_put_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_evicted) |-> (!r_out_hit && (r_out_cmd == CMD_PUT)))
        else $error("eviction reported outside a put miss");

endmodule
